@@ src/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared constants, codes and controller/datapath link types for the
// sorted min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;
  localparam int STAT_W   = 2;

  // cmd field codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // status field codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // value returned by a dequeue on an empty store
  localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1111;

  // datapath operations issued by the controller
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE     = 3'd0;
  localparam op_t OP_INSERT   = 3'd1;
  localparam op_t OP_REMOVE   = 3'd2;
  localparam op_t OP_REJECT   = 3'd3;
  localparam op_t OP_UNDERRUN = 3'd4;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

@@ src/smpq_dp.sv @@
// ----------------------------------------------------------------------------
// smpq_dp
// Sorted cell array with parallel compare, occupancy counter and result
// registers.
// ----------------------------------------------------------------------------
module smpq_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  smpq_pkg::dp_cmd_t                      cmd,
  input  logic signed [smpq_pkg::VAL_W-1:0]      in_value,
  output smpq_pkg::dp_stat_t                     stat,
  output logic signed [smpq_pkg::VAL_W-1:0]      res_value,
  output logic [smpq_pkg::STAT_W-1:0]            res_status,
  output logic [smpq_pkg::CNT_W-1:0]             count
);

  logic signed [smpq_pkg::VAL_W-1:0] entries_r [smpq_pkg::CAPACITY];
  logic signed [smpq_pkg::VAL_W-1:0] ins_val   [smpq_pkg::CAPACITY];
  logic signed [smpq_pkg::VAL_W-1:0] rem_val   [smpq_pkg::CAPACITY];
  logic [smpq_pkg::CAPACITY-1:0]     le_vec;
  logic [smpq_pkg::CNT_W-1:0]        count_r;
  logic [smpq_pkg::CNT_W-1:0]        count_nxt;
  logic signed [smpq_pkg::VAL_W-1:0] value_r;
  logic [smpq_pkg::STAT_W-1:0]       status_r;

  // le_vec: valid cells holding a value <= the new one; a prefix since sorted
  for (genvar g = 0; g < smpq_pkg::CAPACITY; g++) begin : g_cell
    assign le_vec[g] = (smpq_pkg::CNT_W'(g) < count_r) && (entries_r[g] <= in_value);
    if (g == 0) begin : g_first
      assign ins_val[g] = le_vec[g] ? entries_r[g] : in_value;
    end else begin : g_rest
      assign ins_val[g] = le_vec[g]     ? entries_r[g] :
                          le_vec[g - 1] ? in_value     : entries_r[g - 1];
    end
    if (g == smpq_pkg::CAPACITY - 1) begin : g_last
      assign rem_val[g] = entries_r[g];
    end else begin : g_inner
      assign rem_val[g] = entries_r[g + 1];
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd.op)
      smpq_pkg::OP_INSERT: count_nxt = count_r + smpq_pkg::CNT_W'(1);
      smpq_pkg::OP_REMOVE: count_nxt = count_r - smpq_pkg::CNT_W'(1);
      default:             count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // payload: cells and result, no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      smpq_pkg::OP_INSERT: begin
        entries_r <= ins_val;
        value_r   <= '0;
        status_r  <= smpq_pkg::STAT_OK;
      end
      smpq_pkg::OP_REMOVE: begin
        entries_r <= rem_val;
        value_r   <= entries_r[0];
        status_r  <= smpq_pkg::STAT_OK;
      end
      smpq_pkg::OP_REJECT: begin
        value_r  <= '0;
        status_r <= smpq_pkg::STAT_FULL;
      end
      smpq_pkg::OP_UNDERRUN: begin
        value_r  <= smpq_pkg::EMPTY_VALUE;
        status_r <= smpq_pkg::STAT_EMPTY;
      end
      default: begin
      end
    endcase
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == smpq_pkg::CNT_W'(smpq_pkg::CAPACITY));
  assign res_value  = value_r;
  assign res_status = status_r;
  assign count      = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= smpq_pkg::CNT_W'(smpq_pkg::CAPACITY))
    else $error("occupancy above capacity");

  a_insert_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == smpq_pkg::OP_INSERT |=> count_r == $past(count_r) + smpq_pkg::CNT_W'(1))
    else $error("insert did not grow occupancy");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= smpq_pkg::CNT_W'(2) |-> entries_r[0] <= entries_r[1])
    else $error("head cells out of order");

endmodule

@@ src/smpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// smpq_ctrl
// Handshake controller: tracks a pending result and decodes each accepted
// item into a datapath operation.
// ----------------------------------------------------------------------------
module smpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  input  smpq_pkg::dp_stat_t stat,
  output smpq_pkg::dp_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE) || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_HOLD : S_IDLE;
      S_HOLD:  state_nxt = (accept || !out_ready) ? S_HOLD : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.op = smpq_pkg::OP_NONE;
    if (accept) begin
      if (in_cmd == smpq_pkg::CMD_ENQ) begin
        cmd.op = stat.full ? smpq_pkg::OP_REJECT : smpq_pkg::OP_INSERT;
      end else begin
        cmd.op = stat.empty ? smpq_pkg::OP_UNDERRUN : smpq_pkg::OP_REMOVE;
      end
    end
  end

  assign out_valid = (state_r == S_HOLD);

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == smpq_pkg::OP_REJECT |-> stat.full)
    else $error("reject issued while not full");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == smpq_pkg::OP_REMOVE |-> !stat.empty)
    else $error("remove issued on empty store");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op != smpq_pkg::OP_NONE |=> out_valid)
    else $error("accepted item left no result");

endmodule

@@ src/sorted_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Latency: a result is valid the cycle after its item is accepted.
// Throughput: 1 item per cycle unless a result waits with out_ready low.
// A pending result that is not taken holds the input until out_ready.
// Reset (rst_n low, synchronous) empties the queue and drops any result.
// ----------------------------------------------------------------------------
//
// Bounded min-priority queue kept as an ascending row of register cells.
// Enqueue: every valid cell compares itself against the new value in
// parallel; cells at or below it stay, the first larger cell takes the new
// value and everything above shifts up one place. Equal values therefore
// leave in arrival order.
// Dequeue: cell 0 is returned and the row shifts down one place.
// Enqueue when full returns status full; dequeue when empty returns -1111
// with status empty. Every result carries count and empty/full flags.
//
// Structure: smpq_ctrl owns the handshake and decodes each item into one
// datapath operation from the empty/full status; smpq_dp owns the cells,
// the counter and the result registers.
module sorted_min_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [smpq_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smpq_pkg::VAL_W-1:0]   out_value,
  output logic [smpq_pkg::STAT_W-1:0]         out_status,
  output logic [smpq_pkg::OCC_W-1:0]          out_occupancy,
  output logic                                out_is_empty,
  output logic                                out_is_full
);

  smpq_pkg::dp_cmd_t             dp_cmd;
  smpq_pkg::dp_stat_t            dp_stat;
  logic [smpq_pkg::CNT_W-1:0]    count;

  // controller: handshake and operation decode
  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // datapath: sorted cells and result registers
  smpq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .in_value   (in_value),
    .stat       (dp_stat),
    .res_value  (out_value),
    .res_status (out_status),
    .count      (count)
  );

  // count only moves on an accepted item, which also reloads the result,
  // so the live count matches the pending result
  assign out_occupancy = smpq_pkg::OCC_W'(count);
  assign out_is_empty  = dp_stat.empty;
  assign out_is_full   = dp_stat.full;

endmodule
